FILE: rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types, codes and arithmetic helpers for the premultiplied alpha
// blend unit.
// ----------------------------------------------------------------------------
package pab_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned PROD_W = 2 * PIX_W;
    localparam int unsigned LANES = 4;
    localparam logic [PIX_W-1:0] FULL = 8'd255;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_FACTOR = 2'd1;

    typedef enum logic [1:0] {
        MODE_UNDER  = 2'd0,
        MODE_OVER   = 2'd1,
        MODE_ADD    = 2'd2,
        MODE_FACTOR = 2'd3
    } t_mode;

    // per-lane operation chosen at the input stage
    typedef enum logic [2:0] {
        ACT_KEEP,
        ACT_COPY,
        ACT_MUL_SRC,
        ACT_MUL_DST,
        ACT_ADD
    } t_action;

    typedef logic [LANES-1:0][PIX_W-1:0] t_pix;

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [PIX_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(PIX_W+1){1'b0}}, x[PROD_W-1:PIX_W]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] sat8(input logic [PIX_W:0] x);
        return x[PIX_W] ? FULL : x[PIX_W-1:0];
    endfunction

endpackage

FILE: rtl/pab_lane.sv
// ----------------------------------------------------------------------------
// pab_lane
// One channel of the back half of the pipeline: multiply, divide by 255,
// add the other operand and saturate, or pass one operand through. Two register stages.
// ----------------------------------------------------------------------------
module pab_lane (
    input  logic                        i_clk,
    input  pab_pkg::t_action            i_act,
    input  logic [pab_pkg::PIX_W-1:0]   i_m,
    input  logic [pab_pkg::PIX_W-1:0]   i_d,
    input  logic [pab_pkg::PIX_W-1:0]   i_s,
    output logic [pab_pkg::PIX_W-1:0]   o_res
);

    pab_pkg::t_action             r_act;
    logic [pab_pkg::PIX_W-1:0]    r_d;
    logic [pab_pkg::PIX_W-1:0]    r_s;
    logic [pab_pkg::PROD_W-1:0]   r_prod;
    logic [pab_pkg::PROD_W-1:0]   n_prod;
    logic [pab_pkg::PIX_W-1:0]    r_res;
    logic [pab_pkg::PIX_W-1:0]    n_res;
    logic [pab_pkg::PIX_W-1:0]    q;

    always_comb begin
        if (i_act == pab_pkg::ACT_MUL_SRC) begin
            n_prod = i_m * i_s;
        end else begin
            n_prod = i_m * i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= i_act;
        r_d    <= i_d;
        r_s    <= i_s;
        r_prod <= n_prod;
    end

    assign q = pab_pkg::div255(r_prod);

    always_comb begin
        case (r_act)
            pab_pkg::ACT_KEEP:    n_res = r_d;
            pab_pkg::ACT_COPY:    n_res = r_s;
            pab_pkg::ACT_MUL_SRC: n_res = pab_pkg::sat8({1'b0, r_d} + {1'b0, q});
            pab_pkg::ACT_MUL_DST: n_res = pab_pkg::sat8({1'b0, q} + {1'b0, r_s});
            pab_pkg::ACT_ADD:     n_res = pab_pkg::sat8({1'b0, r_d} + {1'b0, r_s});
            default:              n_res = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

FILE: rtl/premul_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// premul_alpha_blend_unit
// Premultiplied alpha compositing of one source/destination pixel pair.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock; busy never rises. Each transaction gives
// one result, shown for one cycle with o_done, after the pipeline stages:
// input decode with the factor product, coverage select, per-channel
// multiply, divide by 255 with add and saturate. The receiver cannot stall,
// so nothing holds the pipeline. Registers are written through the config
// channel, which is always ready; change them only while no pixel is in
// flight.
module premul_alpha_blend_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pab_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pab_pkg::PIX_W-1:0]       i_cfg_data,
    input  logic [pab_pkg::PIX_W-1:0]       i_dst_alpha,
    input  logic [pab_pkg::PIX_W-1:0]       i_dst_chan1,
    input  logic [pab_pkg::PIX_W-1:0]       i_dst_chan2,
    input  logic [pab_pkg::PIX_W-1:0]       i_dst_chan3,
    input  logic [pab_pkg::PIX_W-1:0]       i_src_alpha,
    input  logic [pab_pkg::PIX_W-1:0]       i_src_chan1,
    input  logic [pab_pkg::PIX_W-1:0]       i_src_chan2,
    input  logic [pab_pkg::PIX_W-1:0]       i_src_chan3,
    output logic                            o_done,
    output logic [pab_pkg::PIX_W-1:0]       o_out_alpha,
    output logic [pab_pkg::PIX_W-1:0]       o_out_chan1,
    output logic [pab_pkg::PIX_W-1:0]       o_out_chan2,
    output logic [pab_pkg::PIX_W-1:0]       o_out_chan3
);

    pab_pkg::t_mode                     r_blend_mode;
    logic [pab_pkg::PIX_W-1:0]          r_add_factor;
    logic [3:0]                         r_vld;
    logic                               accept;

    pab_pkg::t_pix                      in_d;
    pab_pkg::t_pix                      in_s;
    pab_pkg::t_action [pab_pkg::LANES-1:0] n1_act;

    pab_pkg::t_pix                      r1_d;
    pab_pkg::t_pix                      r1_s;
    pab_pkg::t_mode                     r1_mode;
    pab_pkg::t_action [pab_pkg::LANES-1:0] r1_act;
    logic [pab_pkg::PROD_W-1:0]         r1_p;

    pab_pkg::t_pix                      r2_d;
    pab_pkg::t_pix                      r2_s;
    pab_pkg::t_action [pab_pkg::LANES-1:0] r2_act;
    logic [pab_pkg::PIX_W-1:0]          r2_m;
    logic [pab_pkg::PIX_W-1:0]          n2_m;

    pab_pkg::t_pix                      res;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= pab_pkg::MODE_OVER;
            r_add_factor <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pab_pkg::CFG_BLEND_MODE: r_blend_mode <= pab_pkg::t_mode'(i_cfg_data[1:0]);
                pab_pkg::CFG_ADD_FACTOR: r_add_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], accept};
        end
    end

    assign in_d = {i_dst_chan3, i_dst_chan2, i_dst_chan1, i_dst_alpha};
    assign in_s = {i_src_chan3, i_src_chan2, i_src_chan1, i_src_alpha};

    // stage 1: choose per-lane operation from the alpha shortcuts
    always_comb begin
        for (int i = 0; i < pab_pkg::LANES; i++) begin
            case (r_blend_mode)
                pab_pkg::MODE_UNDER: begin
                    if (i_dst_alpha == pab_pkg::FULL) n1_act[i] = pab_pkg::ACT_KEEP;
                    else if (i_dst_alpha == '0)       n1_act[i] = pab_pkg::ACT_COPY;
                    else                              n1_act[i] = pab_pkg::ACT_MUL_SRC;
                end
                pab_pkg::MODE_OVER: begin
                    if (i_src_alpha == '0)                 n1_act[i] = pab_pkg::ACT_KEEP;
                    else if (i_src_alpha == pab_pkg::FULL) n1_act[i] = pab_pkg::ACT_COPY;
                    else                                   n1_act[i] = pab_pkg::ACT_MUL_DST;
                end
                pab_pkg::MODE_ADD: begin
                    if (i_dst_alpha == '0 || i_src_alpha == pab_pkg::FULL) begin
                        n1_act[i] = pab_pkg::ACT_COPY;
                    end else begin
                        n1_act[i] = pab_pkg::ACT_ADD;
                    end
                end
                default: begin
                    if (i_dst_alpha == '0) n1_act[i] = pab_pkg::ACT_COPY;
                    else if (i == 0)       n1_act[i] = pab_pkg::ACT_ADD;
                    else                   n1_act[i] = pab_pkg::ACT_MUL_DST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d    <= in_d;
        r1_s    <= in_s;
        r1_mode <= r_blend_mode;
        r1_act  <= n1_act;
        r1_p    <= i_src_alpha * (pab_pkg::FULL - r_add_factor);
    end

    // stage 2: coverage multiplier
    always_comb begin
        case (r1_mode)
            pab_pkg::MODE_UNDER:  n2_m = pab_pkg::FULL - r1_d[0];
            pab_pkg::MODE_FACTOR: n2_m = pab_pkg::FULL - pab_pkg::div255(r1_p);
            default:              n2_m = pab_pkg::FULL - r1_s[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_d   <= r1_d;
        r2_s   <= r1_s;
        r2_act <= r1_act;
        r2_m   <= n2_m;
    end

    // stages 3 and 4
    for (genvar g = 0; g < pab_pkg::LANES; g++) begin : g_lane
        pab_lane u_lane (
            .i_clk (i_clk),
            .i_act (r2_act[g]),
            .i_m   (r2_m),
            .i_d   (r2_d[g]),
            .i_s   (r2_s[g]),
            .o_res (res[g])
        );
    end

    assign o_done      = r_vld[3];
    assign o_out_alpha = res[0];
    assign o_out_chan1 = res[1];
    assign o_out_chan2 = res[2];
    assign o_out_chan3 = res[3];

endmodule

FILE: rtl/pab_checker.sv
// ----------------------------------------------------------------------------
// pab_checker
// Port-level checks on transaction latency and port behavior of the blend
// unit, bound to the top level.
// ----------------------------------------------------------------------------
module pab_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic                            o_done
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("transaction result missing");

    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 4))
        else $error("result without transaction");

    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind premul_alpha_blend_unit pab_checker u_pab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .o_done      (o_done)
);
